// ===== src/ebisp_pkg.sv =====
// Shared types and constants for the e-book index stream parser.
// No dependencies.
package ebisp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic [31:0] page_start;
    logic [31:0] page_count;
    logic [1:0]  error_code;
    logic        last_of_run;
  } res_t;

  // One parsed byte's worth of results, in delivery order:
  // UTF-8 bytes, entry done, parse complete, error.
  typedef struct packed {
    logic [1:0]      utf_n;
    logic [2:0][7:0] utf;
    logic            entry;
    logic [31:0]     page_start;
    logic [31:0]     page_count;
    logic            done;
    logic            err;
    logic [1:0]      code;
  } cmd_t;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_TRUNC = 2'd0;
  localparam logic [1:0] ERR_ODD   = 2'd1;
  localparam logic [1:0] ERR_MAGIC = 2'd2;

  localparam logic [31:0] NULL_LEN    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_BYTES = 32'd26;
  localparam logic [31:0] FIXED_SKIP  = 32'd28;
  localparam logic [31:0] EXTRA_SKIP  = 32'd16;
  localparam logic [31:0] WORD_BYTES  = 32'd4;

  localparam logic [15:0] UTF_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF_LEAD2     = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
  localparam logic [7:0]  UTF_CONT      = 8'h80;

  // ASCII of the 13-character magic title.
  function automatic logic [7:0] magic_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h72;
      4'd1:    c = 8'h4D;
      4'd2:    c = 8'h20;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h70;
      4'd5:    c = 8'h75;
      4'd6:    c = 8'h62;
      4'd7:    c = 8'h20;
      4'd8:    c = 8'h69;
      4'd9:    c = 8'h6E;
      4'd10:   c = 8'h64;
      4'd11:   c = 8'h65;
      4'd12:   c = 8'h78;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/ebook_index_stream_parser.sv =====
// Top level of the e-book index stream parser.
// Depends on ebisp_pkg, ebisp_front, ebisp_cmd_fifo, ebisp_back.
//
// Takes one file byte per cycle on the in_ channel and delivers results on
// the out_ channel, one per cycle while out_ready holds. The parser front end
// classifies every byte combinationally and posts its results as one request
// into a queue of QUEUE_DEPTH entries; the sequencer drains one result item
// per cycle unless out_ready stalls it, so a byte that yields k results (at
// most four: a 3-byte UTF-8 unit plus a truncation error) holds the sequencer
// until all k are issued. Input stalls only when the queue is full. Reset
// needs no clearing pass; after a byte flagged end_of_file the parser is
// ready for a new file on the next cycle.
module ebook_index_stream_parser import ebisp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t head;

  ebisp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ebisp_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (head)
  );

  ebisp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .head      (head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/ebisp_front.sv =====
// Byte-level parser: walks the index file layout and turns each byte that
// yields results into a result request for the back end. Depends on ebisp_pkg.
module ebisp_front import ebisp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    PH_MAGIC_LEN, PH_MAGIC_BODY, PH_VERSION, PH_SKIP, PH_TITLE_LEN,
    PH_TITLE_BODY, PH_TOC_COUNT, PH_TOC_ENTRY, PH_SPINE_COUNT,
    PH_SPINE_ENTRY, PH_DONE, PH_FAILED
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] fbl_r, fbl_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] items_r, items_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        mism_r, mism_nxt;
  logic [31:0] sps_r, sps_nxt;

  logic        accept;
  logic        live;
  logic        in_word;
  logic [31:0] word;
  logic [31:0] fb;
  logic [31:0] items_dec;
  logic [4:0]  pos;
  logic [15:0] unit;
  logic        odd_len;
  logic        empty_len;
  logic        mism_new;
  logic        has_res;

  assign accept = in_valid && in_ready;
  assign in_ready = cmd_ready;

  always_comb begin
    case (phase_r)
      PH_MAGIC_LEN, PH_VERSION, PH_TITLE_LEN, PH_TOC_COUNT, PH_SPINE_COUNT: in_word = 1'b1;
      PH_TOC_ENTRY:   in_word = (step_r != 3'd1) && (step_r != 3'd3);
      PH_SPINE_ENTRY: in_word = (step_r != 3'd1);
      default:        in_word = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    fbl_nxt   = fbl_r;
    shift_nxt = shift_r;
    items_nxt = items_r;
    step_nxt  = step_r;
    held_nxt  = held_r;
    mism_nxt  = mism_r;
    sps_nxt   = sps_r;
    cmd       = '0;
    word      = {shift_r[23:0], in_data.in_byte};
    fb        = (fbl_r != '0) ? fbl_r - 32'd1 : fbl_r;
    items_dec = items_r - 32'd1;
    pos       = 5'(MAGIC_BYTES - 32'd1 - fb);
    unit      = {held_r, in_data.in_byte};
    odd_len   = word[0] && (word != NULL_LEN);
    empty_len = (word == NULL_LEN) || (word == '0);
    live      = (phase_r != PH_DONE) && (phase_r != PH_FAILED);
    mism_new  = mism_r;

    if (live && in_word) begin
      shift_nxt = word;
      fbl_nxt   = fb;
      if (fb == '0) begin
        case (phase_r)
          PH_MAGIC_LEN: begin
            if (odd_len) begin
              cmd.err = 1'b1; cmd.code = ERR_ODD; phase_nxt = PH_FAILED;
            end else if (empty_len) begin
              cmd.err = 1'b1; cmd.code = ERR_MAGIC; phase_nxt = PH_FAILED;
            end else begin
              fbl_nxt   = word;
              mism_nxt  = (word != MAGIC_BYTES);
              phase_nxt = PH_MAGIC_BODY;
            end
          end
          PH_VERSION: begin
            fbl_nxt   = (word >= 32'd2) ? FIXED_SKIP + EXTRA_SKIP : FIXED_SKIP;
            phase_nxt = PH_SKIP;
          end
          PH_TITLE_LEN: begin
            if (odd_len) begin
              cmd.err = 1'b1; cmd.code = ERR_ODD; phase_nxt = PH_FAILED;
            end else if (!empty_len) begin
              fbl_nxt   = word;
              phase_nxt = PH_TITLE_BODY;
            end else begin
              phase_nxt = PH_TOC_COUNT;
              fbl_nxt   = WORD_BYTES;
              shift_nxt = '0;
            end
          end
          PH_TOC_COUNT: begin
            items_nxt = word;
            fbl_nxt   = WORD_BYTES;
            shift_nxt = '0;
            step_nxt  = '0;
            phase_nxt = (word == '0) ? PH_SPINE_COUNT : PH_TOC_ENTRY;
          end
          PH_TOC_ENTRY: begin
            if (step_r == 3'd0 || step_r == 3'd2) begin
              if (odd_len) begin
                cmd.err = 1'b1; cmd.code = ERR_ODD; phase_nxt = PH_FAILED;
              end else if (!empty_len) begin
                fbl_nxt  = word;
                step_nxt = step_r + 3'd1;
              end else begin
                step_nxt  = step_r + 3'd2;
                fbl_nxt   = WORD_BYTES;
                shift_nxt = '0;
              end
            end else if (step_r == 3'd4) begin
              step_nxt  = 3'd5;
              fbl_nxt   = WORD_BYTES;
              shift_nxt = '0;
            end else begin
              items_nxt = items_dec;
              fbl_nxt   = WORD_BYTES;
              shift_nxt = '0;
              if (items_dec == '0) begin
                phase_nxt = PH_SPINE_COUNT;
              end else begin
                step_nxt = '0;
              end
            end
          end
          PH_SPINE_COUNT: begin
            items_nxt = word;
            if (word == '0) begin
              cmd.done  = 1'b1;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_SPINE_ENTRY;
              step_nxt  = '0;
              fbl_nxt   = WORD_BYTES;
              shift_nxt = '0;
            end
          end
          PH_SPINE_ENTRY: begin
            if (step_r == 3'd0) begin
              if (odd_len) begin
                cmd.err = 1'b1; cmd.code = ERR_ODD; phase_nxt = PH_FAILED;
              end else if (!empty_len) begin
                fbl_nxt  = word;
                step_nxt = 3'd1;
              end else begin
                step_nxt  = 3'd2;
                fbl_nxt   = WORD_BYTES;
                shift_nxt = '0;
              end
            end else if (step_r == 3'd5) begin
              cmd.entry      = 1'b1;
              cmd.page_start = sps_r;
              cmd.page_count = word;
              items_nxt      = items_dec;
              if (items_dec == '0) begin
                cmd.done  = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                step_nxt  = '0;
                fbl_nxt   = WORD_BYTES;
                shift_nxt = '0;
              end
            end else begin
              if (step_r == 3'd4) begin
                sps_nxt = word;
              end
              step_nxt  = step_r + 3'd1;
              fbl_nxt   = WORD_BYTES;
              shift_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (live && fbl_r != '0) begin
      fbl_nxt = fb;
      if (phase_r == PH_MAGIC_BODY) begin
        if (!mism_r && pos < 5'd26) begin
          if (in_data.in_byte != (pos[0] ? magic_char(pos[4:1]) : 8'h00)) begin
            mism_new = 1'b1;
          end
        end
        mism_nxt = mism_new;
        if (fb == '0) begin
          if (mism_new) begin
            cmd.err = 1'b1; cmd.code = ERR_MAGIC; phase_nxt = PH_FAILED;
          end else begin
            phase_nxt = PH_VERSION;
            fbl_nxt   = WORD_BYTES;
            shift_nxt = '0;
          end
        end
      end else begin
        if (phase_r == PH_SPINE_ENTRY) begin
          if (fb[0]) begin
            held_nxt = in_data.in_byte;
          end else if (unit < UTF_ONE_LIMIT) begin
            cmd.utf_n  = 2'd1;
            cmd.utf[0] = unit[7:0];
          end else if (unit < UTF_TWO_LIMIT) begin
            cmd.utf_n  = 2'd2;
            cmd.utf[0] = UTF_LEAD2 | {3'b000, unit[10:6]};
            cmd.utf[1] = UTF_CONT | {2'b00, unit[5:0]};
          end else begin
            cmd.utf_n  = 2'd3;
            cmd.utf[0] = UTF_LEAD3 | {4'b0000, unit[15:12]};
            cmd.utf[1] = UTF_CONT | {2'b00, unit[11:6]};
            cmd.utf[2] = UTF_CONT | {2'b00, unit[5:0]};
          end
        end
        if (fb == '0) begin
          fbl_nxt   = WORD_BYTES;
          shift_nxt = '0;
          case (phase_r)
            PH_SKIP:       phase_nxt = PH_TITLE_LEN;
            PH_TITLE_BODY: phase_nxt = PH_TOC_COUNT;
            default:       step_nxt  = step_r + 3'd1;
          endcase
        end
      end
    end

    if (in_data.end_of_file) begin
      if (phase_nxt != PH_DONE && phase_nxt != PH_FAILED) begin
        cmd.err  = 1'b1;
        cmd.code = ERR_TRUNC;
      end
      phase_nxt = PH_MAGIC_LEN;
      fbl_nxt   = WORD_BYTES;
      shift_nxt = '0;
      items_nxt = '0;
      step_nxt  = '0;
      held_nxt  = '0;
      mism_nxt  = 1'b0;
      sps_nxt   = '0;
    end
  end

  assign has_res   = (cmd.utf_n != 2'd0) || cmd.entry || cmd.done || cmd.err;
  assign cmd_valid = accept && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC_LEN;
      fbl_r   <= WORD_BYTES;
      shift_r <= '0;
      items_r <= '0;
      step_r  <= '0;
      held_r  <= '0;
      mism_r  <= 1'b0;
      sps_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fbl_r   <= fbl_nxt;
      shift_r <= shift_nxt;
      items_r <= items_nxt;
      step_r  <= step_nxt;
      held_r  <= held_nxt;
      mism_r  <= mism_nxt;
      sps_r   <= sps_nxt;
    end
  end

  a_eof_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.end_of_file |=> phase_r == PH_MAGIC_LEN && fbl_r == WORD_BYTES)
    else $error("parser not rearmed after end of file");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> in_valid && cmd_ready)
    else $error("request pushed without an accepted byte");

endmodule

// ===== src/ebisp_cmd_fifo.sv =====
// Small register queue of result requests between parser and result sequencer.
// Depends on ebisp_pkg.
module ebisp_cmd_fifo import ebisp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== src/ebisp_back.sv =====
// Result sequencer: expands each queued request into one to four result
// items, one per cycle while out_ready holds, through an output register. Depends on ebisp_pkg.
module ebisp_back import ebisp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic pop_valid,
  output logic pop_ready,
  input  cmd_t head,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic [1:0] step_r;
  logic [2:0] total;
  logic [1:0] j;
  logic       last;
  logic       issue;
  logic       slot_free;
  logic       out_valid_r;
  res_t       out_r;
  res_t       item;

  assign total     = 3'(head.utf_n) + 3'(head.entry) + 3'(head.done) + 3'(head.err);
  assign last      = (3'(step_r) + 3'd1 == total);
  assign slot_free = !out_valid_r || out_ready;
  assign issue     = pop_valid && slot_free;
  assign pop_ready = issue && last;
  assign j         = step_r - head.utf_n;

  always_comb begin
    item = '0;
    item.last_of_run = last;
    if (3'(step_r) < 3'(head.utf_n)) begin
      item.kind      = KIND_TEXT;
      item.text_byte = head.utf[step_r];
    end else if (head.entry && j == 2'd0) begin
      item.kind       = KIND_ENTRY;
      item.page_start = head.page_start;
      item.page_count = head.page_count;
    end else if (head.done && j == {1'b0, head.entry}) begin
      item.kind = KIND_DONE;
    end else begin
      item.kind       = KIND_ERROR;
      item.error_code = head.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        out_valid_r <= 1'b1;
        step_r      <= last ? 2'd0 : step_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid |-> 3'(step_r) < total)
    else $error("sequencer step past end of request");

  a_step_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 2'd0 |-> pop_valid)
    else $error("partial request lost from queue");

endmodule
